/* src/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int VALUE_BITS_DEF    = 32;
    localparam int PRIORITY_BITS_DEF = 16;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_spq_cmd;

endpackage

/* src/spq_if.sv */
`timescale 1ns / 1ps

interface spq_in_if #(
    parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [VALUE_BITS-1:0]           item_value;
    logic signed [PRIORITY_BITS-1:0] item_priority;

    modport source (output valid, opcode, item_value, item_priority, input ready);
    modport sink   (input valid, opcode, item_value, item_priority, output ready);
endinterface

interface spq_out_if #(
    parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
);
    localparam int OCC_BITS = $clog2(CAPACITY + 1);

    logic                            valid;
    logic                            ready;
    logic [VALUE_BITS-1:0]           out_value;
    logic signed [PRIORITY_BITS-1:0] out_priority;
    logic [1:0]                      status;
    logic [OCC_BITS-1:0]             occupancy;
    logic                            is_empty;

    modport source (output valid, out_value, out_priority, status, occupancy, is_empty,
                    input ready);
    modport sink   (input valid, out_value, out_priority, status, occupancy, is_empty,
                    output ready);
endinterface

/* src/spq_ctrl.sv */
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output spq_pkg::t_spq_cmd o_cmd
);
    import spq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = ST_RESP;
            end
            ST_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* src/spq_datapath.sv */
`timescale 1ns / 1ps

module spq_datapath #(
    parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
    parameter int OCC_BITS      = $clog2(CAPACITY + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spq_pkg::t_spq_cmd               i_cmd,
    input  logic                            i_opcode,
    input  logic [VALUE_BITS-1:0]           i_item_value,
    input  logic signed [PRIORITY_BITS-1:0] i_item_priority,
    output logic [VALUE_BITS-1:0]           o_out_value,
    output logic signed [PRIORITY_BITS-1:0] o_out_priority,
    output logic [1:0]                      o_status,
    output logic [OCC_BITS-1:0]             o_occupancy,
    output logic                            o_is_empty
);
    import spq_pkg::*;

    localparam logic [OCC_BITS-1:0] FULL_COUNT = OCC_BITS'(CAPACITY);

    logic                            r_op;
    logic [VALUE_BITS-1:0]           r_in_value;
    logic signed [PRIORITY_BITS-1:0] r_in_prio;

    logic [OCC_BITS-1:0]             r_count;
    logic [OCC_BITS-1:0]             n_count;

    logic [VALUE_BITS-1:0]           r_cell_value [CAPACITY];
    logic signed [PRIORITY_BITS-1:0] r_cell_prio  [CAPACITY];
    logic [CAPACITY-1:0]             w_keep;

    logic                            w_full;
    logic                            w_empty;
    logic                            w_do_enq;
    logic                            w_do_deq;

    logic [VALUE_BITS-1:0]           r_out_value;
    logic signed [PRIORITY_BITS-1:0] r_out_prio;
    logic [1:0]                      r_status;
    logic [OCC_BITS-1:0]             r_occ;
    logic                            r_empty;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_opcode;
            r_in_value <= i_item_value;
            r_in_prio  <= i_item_priority;
        end
    end

    assign w_full   = (r_count == FULL_COUNT);
    assign w_empty  = (r_count == '0);
    assign w_do_enq = i_cmd.execute && (r_op == OP_ENQ) && !w_full;
    assign w_do_deq = i_cmd.execute && (r_op == OP_DEQ) && !w_empty;

    // occupied cells whose priority is not below the new one form a prefix
    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            assign w_keep[i] = (OCC_BITS'(i) < r_count) && (r_cell_prio[i] >= r_in_prio);

            always_ff @(posedge i_clk) begin
                if (w_do_enq && !w_keep[i]) begin
                    if (i == 0) begin
                        r_cell_value[i] <= r_in_value;
                        r_cell_prio[i]  <= r_in_prio;
                    end else if (w_keep[(i == 0) ? 0 : i-1]) begin
                        r_cell_value[i] <= r_in_value;
                        r_cell_prio[i]  <= r_in_prio;
                    end else begin
                        r_cell_value[i] <= r_cell_value[(i == 0) ? 0 : i-1];
                        r_cell_prio[i]  <= r_cell_prio[(i == 0) ? 0 : i-1];
                    end
                end else if (w_do_deq && (i < CAPACITY - 1)) begin
                    r_cell_value[i] <= r_cell_value[(i < CAPACITY - 1) ? i+1 : i];
                    r_cell_prio[i]  <= r_cell_prio[(i < CAPACITY - 1) ? i+1 : i];
                end
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_do_enq) begin
            n_count = r_count + 1'b1;
        end else if (w_do_deq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out_value <= '0;
            r_out_prio  <= '0;
            r_status    <= STS_DONE;
            if (r_op == OP_ENQ) begin
                if (w_full) begin
                    r_status <= STS_FULL;
                end
            end else if (w_empty) begin
                r_status <= STS_EMPTY;
            end else begin
                r_out_value <= r_cell_value[0];
                r_out_prio  <= r_cell_prio[0];
            end
            r_occ   <= n_count;
            r_empty <= (n_count == '0);
        end
    end

    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_prio;
    assign o_status       = r_status;
    assign o_occupancy    = r_occ;
    assign o_is_empty     = r_empty;
endmodule

/* src/stable_sorted_priority_queue_top.sv */
`timescale 1ns / 1ps

// Stable sorted priority queue, highest priority first.
// Input channel i_in carries one item: opcode (enqueue or dequeue), a value
// and a signed priority. Output channel o_out returns exactly one item per
// input item: the dequeued value and priority (zero otherwise), a status
// code (done, enqueue dropped when full, dequeue on empty), the occupancy
// after the operation and an empty flag.
// Entries of equal priority leave first in, first out.
// Each item passes through the controller states accept, execute, in which
// the cell chain shifts or inserts, and respond, with the result shown on
// o_out. The controller handles one item at a time, so the next item is
// accepted in the cycle after the result is taken.
// If the receiver stalls, the result holds on o_out and i_in.ready stays low
// until it is taken.
// Synchronous reset empties the queue; cell contents are not cleared and no
// clearing pass is needed, since only occupied cells are ever read.

module stable_sorted_priority_queue_top #(
    parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    localparam int OCC_BITS = $clog2(CAPACITY + 1);

    t_spq_cmd w_cmd;
    logic     w_in_ready;
    logic     w_out_valid;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    spq_datapath #(
        .CAPACITY      (CAPACITY),
        .VALUE_BITS    (VALUE_BITS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .OCC_BITS      (OCC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_opcode        (i_in.opcode),
        .i_item_value    (i_in.item_value),
        .i_item_priority (i_in.item_priority),
        .o_out_value     (o_out.out_value),
        .o_out_priority  (o_out.out_priority),
        .o_status        (o_out.status),
        .o_occupancy     (o_out.occupancy),
        .o_is_empty      (o_out.is_empty)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_ready && w_out_valid))
        else $error("input ready while a result is pending");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready) |=> !w_out_valid)
        else $error("result shown in the cycle after accept");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_valid && o_out.status == STS_FULL) |-> (o_out.occupancy == OCC_BITS'(CAPACITY)))
        else $error("enqueue dropped while queue not full");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_valid |-> (o_out.is_empty == (o_out.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");
endmodule
